FILE: src/nfp_pkg.sv
`timescale 1ns / 1ps

package nfp_pkg;

    localparam int SLOT_W  = 8;
    localparam int FIELD_W = 10;
    localparam int CNT_CFG_W = 9;
    localparam int NIDX_W  = 8;
    localparam int CELL_W  = 16;
    localparam int APB_W   = 32;
    localparam int PADDR_W = 3;

    localparam logic [0:0] REG_POINT_COUNT = 1'b0;
    localparam logic [CNT_CFG_W-1:0] POINT_COUNT_RESET = 9'd1;

    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    typedef struct packed {
        logic               mode;
        logic [SLOT_W-1:0]  point_slot;
        logic [FIELD_W-1:0] coord_x;
        logic [FIELD_W-1:0] coord_y;
    } nfp_in_t;

    typedef struct packed {
        logic [NIDX_W-1:0] nearest_index;
        logic [CELL_W-1:0] cell_value;
    } nfp_out_t;

endpackage

FILE: src/nearest_feature_point_cell_top.sv
`timescale 1ns / 1ps

// channel   direction  handshake                    payload
// in        input      in_valid / in_ready          in_data   (nfp_in_t)
// out       output     out_valid / out_ready        out_data  (nfp_out_t)
// cfg       input      psel penable pwrite pready   paddr pwdata prdata
//
// a load transfer writes the point table directly
// a query reads the table once per point through the single read port, feeds a
// squaring / running-minimum distance pipe, then takes 16 divide steps
// in is not ready while a query runs; one finished result may wait in the output
// register while the next item is taken
// reset clears control state and sets point_count to 1; table contents stay unknown

module nearest_feature_point_cell_top
    import nfp_pkg::*;
#(
    parameter int MAX_POINTS = 256,
    parameter int COORD_BITS = 10
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  nfp_in_t            in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output nfp_out_t           out_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [APB_W-1:0]   pwdata,
    output logic [APB_W-1:0]   prdata,
    output logic               pready
);

    localparam int IDX_W = $clog2(MAX_POINTS);
    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam int N_W   = (CNT_W > CNT_CFG_W) ? CNT_W : CNT_CFG_W;
    localparam int PT_W  = 2 * COORD_BITS;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_DIV  = 4'b0100,
        S_DONE = 4'b1000
    } state_t;

    state_t                state_reg;
    state_t                state_next;
    logic [CNT_CFG_W-1:0]  point_count_reg;
    logic [N_W-1:0]        count_ext;
    logic [CNT_W-1:0]      active_n;
    logic [CNT_W-1:0]      n_reg;
    logic [CNT_W-1:0]      issue_reg;
    logic [CNT_W-1:0]      issue_next;
    logic [COORD_BITS-1:0] px_reg;
    logic [COORD_BITS-1:0] py_reg;
    logic                  v1_reg;
    logic [IDX_W-1:0]      idx1_reg;
    logic                  out_valid_reg;
    nfp_out_t              out_data_reg;

    logic                  in_xfer;
    logic                  is_query;
    logic                  ram_we;
    logic                  issuing;
    logic [PT_W-1:0]       ram_rdata;
    logic                  dist_busy;
    logic [IDX_W-1:0]      best_idx;
    logic                  div_start;
    logic                  div_busy;
    logic [CELL_W-1:0]     quotient;
    logic                  out_free;
    logic                  cfg_write;

    // configuration
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == REG_POINT_COUNT) ? APB_W'(point_count_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            point_count_reg <= POINT_COUNT_RESET;
        end
        else if (cfg_write && (paddr[2] == REG_POINT_COUNT))
        begin
            point_count_reg <= pwdata[CNT_CFG_W-1:0];
        end
    end

    // zero counts as one, large counts saturate
    assign count_ext = N_W'(point_count_reg);
    always_comb
    begin
        priority if (count_ext == '0)
        begin
            active_n = CNT_W'(1);
        end
        else if (count_ext > N_W'(MAX_POINTS))
        begin
            active_n = CNT_W'(MAX_POINTS);
        end
        else
        begin
            active_n = CNT_W'(count_ext);
        end
    end

    // input side
    assign in_ready = (state_reg == S_IDLE);
    assign in_xfer  = in_valid && in_ready;
    assign is_query = in_xfer && (in_data.mode == MODE_QUERY);
    assign ram_we   = in_xfer && (in_data.mode == MODE_LOAD)
                      && (32'(in_data.point_slot) < MAX_POINTS);

    assign issuing    = (state_reg == S_SCAN) && (issue_reg < n_reg);
    assign issue_next = is_query ? '0 : (issuing ? issue_reg + 1'b1 : issue_reg);

    nfp_ram #(
        .WIDTH (PT_W),
        .DEPTH (MAX_POINTS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (IDX_W'(in_data.point_slot)),
        .wdata ({COORD_BITS'(in_data.coord_x), COORD_BITS'(in_data.coord_y)}),
        .re    (issuing),
        .raddr (IDX_W'(issue_reg)),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk)
    begin
        if (is_query)
        begin
            px_reg <= COORD_BITS'(in_data.coord_x);
            py_reg <= COORD_BITS'(in_data.coord_y);
            n_reg  <= active_n;
        end
        if (issuing)
        begin
            idx1_reg <= IDX_W'(issue_reg);
        end
    end

    nfp_dist #(
        .COORD_BITS (COORD_BITS),
        .MAX_POINTS (MAX_POINTS)
    ) u_dist (
        .clk      (clk),
        .rst_n    (rst_n),
        .clear    (is_query),
        .pt_valid (v1_reg),
        .pt_idx   (idx1_reg),
        .pt_x     (ram_rdata[PT_W-1:COORD_BITS]),
        .pt_y     (ram_rdata[COORD_BITS-1:0]),
        .px       (px_reg),
        .py       (py_reg),
        .busy     (dist_busy),
        .best_idx (best_idx)
    );

    assign div_start = (state_reg == S_SCAN) && !issuing && !v1_reg && !dist_busy;

    nfp_div #(
        .MAX_POINTS (MAX_POINTS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (best_idx),
        .divisor  (n_reg),
        .busy     (div_busy),
        .quotient (quotient)
    );

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (is_query)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (div_start)
                begin
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (!div_busy)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            issue_reg     <= '0;
            v1_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            issue_reg <= issue_next;
            v1_reg    <= issuing;
            if ((state_reg == S_DONE) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == S_DONE) && out_free)
        begin
            out_data_reg.nearest_index <= NIDX_W'(best_idx);
            out_data_reg.cell_value    <= quotient;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

FILE: src/nfp_ram.sv
`timescale 1ns / 1ps

module nfp_ram #(
    parameter int WIDTH = 20,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: src/nfp_dist.sv
`timescale 1ns / 1ps

module nfp_dist
    import nfp_pkg::*;
#(
    parameter int COORD_BITS = 10,
    parameter int MAX_POINTS = 256
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          clear,
    input  logic                          pt_valid,
    input  logic [$clog2(MAX_POINTS)-1:0] pt_idx,
    input  logic [COORD_BITS-1:0]         pt_x,
    input  logic [COORD_BITS-1:0]         pt_y,
    input  logic [COORD_BITS-1:0]         px,
    input  logic [COORD_BITS-1:0]         py,
    output logic                          busy,
    output logic [$clog2(MAX_POINTS)-1:0] best_idx
);

    localparam int IDX_W = $clog2(MAX_POINTS);
    localparam int SQ_W  = 2 * COORD_BITS;
    localparam int D_W   = SQ_W + 1;

    logic [COORD_BITS-1:0] dx;
    logic [COORD_BITS-1:0] dy;
    logic [SQ_W-1:0]       sqx_reg;
    logic [SQ_W-1:0]       sqy_reg;
    logic [IDX_W-1:0]      idx2_reg;
    logic                  v2_reg;
    logic [D_W-1:0]        sum;
    logic [D_W-1:0]        best_d_reg;
    logic [IDX_W-1:0]      best_idx_reg;

    assign dx  = (pt_x >= px) ? (pt_x - px) : (px - pt_x);
    assign dy  = (pt_y >= py) ? (pt_y - py) : (py - pt_y);
    assign sum = D_W'(sqx_reg) + D_W'(sqy_reg);

    // squaring stage
    always_ff @(posedge clk)
    begin
        if (pt_valid)
        begin
            sqx_reg  <= dx * dx;
            sqy_reg  <= dy * dy;
            idx2_reg <= pt_idx;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else
        begin
            v2_reg <= pt_valid;
        end
    end

    // running minimum, strict compare keeps the lowest index on ties
    always_ff @(posedge clk)
    begin
        if (clear)
        begin
            best_d_reg   <= '1;
            best_idx_reg <= '0;
        end
        else if (v2_reg && (sum < best_d_reg))
        begin
            best_d_reg   <= sum;
            best_idx_reg <= idx2_reg;
        end
    end

    assign busy     = v2_reg;
    assign best_idx = best_idx_reg;

endmodule

FILE: src/nfp_div.sv
`timescale 1ns / 1ps

module nfp_div
    import nfp_pkg::*;
#(
    parameter int MAX_POINTS = 256
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [$clog2(MAX_POINTS)-1:0]   dividend,
    input  logic [$clog2(MAX_POINTS+1)-1:0] divisor,
    output logic                            busy,
    output logic [CELL_W-1:0]               quotient
);

    localparam int CNT_W  = $clog2(MAX_POINTS + 1);
    localparam int STEP_W = $clog2(CELL_W + 1);

    logic [CNT_W-1:0]  rem_reg;
    logic [CNT_W-1:0]  rem_next;
    logic [CELL_W-1:0] q_reg;
    logic [STEP_W-1:0] step_reg;
    logic              busy_reg;
    logic [CNT_W:0]    shifted;
    logic              ge;

    // restoring fraction division, remainder stays below the divisor
    assign shifted  = {rem_reg, 1'b0};
    assign ge       = shifted >= {1'b0, divisor};
    assign rem_next = ge ? CNT_W'(shifted - {1'b0, divisor}) : CNT_W'(shifted);

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= CNT_W'(dividend);
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            q_reg   <= {q_reg[CELL_W-2:0], ge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            step_reg <= '0;
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg + 1'b1;
            if (step_reg == STEP_W'(CELL_W - 1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    assign busy     = busy_reg;
    assign quotient = q_reg;

endmodule

FILE: tb/nearest_feature_point_cell_top_tb.sv
`timescale 1ns / 1ps

module nearest_feature_point_cell_top_tb;
    import nfp_pkg::*;

    localparam int CLK_PERIOD   = 8;
    localparam int TABLE_DEPTH  = 256;
    localparam int TARGET_ITEMS = 750;
    localparam int QUIET_LIMIT  = 5000;
    localparam int LONG_HOLD    = 800;
    localparam logic [PADDR_W-1:0] POINT_COUNT_ADDR = PADDR_W'(4 * REG_POINT_COUNT);

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic               in_ready;
    nfp_in_t            in_data   = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    nfp_out_t           out_data;
    logic               psel      = 1'b0;
    logic               penable   = 1'b0;
    logic               pwrite    = 1'b0;
    logic [PADDR_W-1:0] paddr     = '0;
    logic [APB_W-1:0]   pwdata    = '0;
    logic [APB_W-1:0]   prdata;
    logic               pready;

    nfp_in_t              feed_items[$];
    nfp_out_t             nearest_cells[$];
    logic [FIELD_W-1:0]   point_x [TABLE_DEPTH];
    logic [FIELD_W-1:0]   point_y [TABLE_DEPTH];
    logic [CNT_CFG_W-1:0] point_count_cfg = POINT_COUNT_RESET;

    bit          slot_loaded [TABLE_DEPTH];
    int unsigned gen_count      = 1;
    int          items_queued   = 0;
    int          result_errors  = 0;
    int          quiet_cycles   = 0;
    int          send_gap       = 0;
    int          send_calm      = 0;
    int          recv_stall     = 0;
    int          recv_calm      = 0;
    int          hold_left      = 0;
    bit          long_hold_done = 1'b0;

    nearest_feature_point_cell_top dut (.*);

    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic int unsigned active_points(input logic [CNT_CFG_W-1:0] cfg);
        if (cfg == 0)
            return 1;
        if (cfg > TABLE_DEPTH)
            return TABLE_DEPTH;
        return cfg;
    endfunction

    function automatic nfp_out_t nearest_cell(input logic [FIELD_W-1:0] px,
                                              input logic [FIELD_W-1:0] py);
        int unsigned     n;
        int unsigned     best;
        longint unsigned dx, dy, sq_dist, best_sq;
        nfp_out_t        res;
        n = active_points(point_count_cfg);
        best = 0;
        best_sq = '1;
        for (int i = 0; i < n; i++)
        begin
            dx = (point_x[i] >= px) ? point_x[i] - px : px - point_x[i];
            dy = (point_y[i] >= py) ? point_y[i] - py : py - point_y[i];
            sq_dist = dx * dx + dy * dy;
            if (i == 0 || sq_dist < best_sq)
            begin
                best_sq = sq_dist;
                best = i;
            end
        end
        res.nearest_index = NIDX_W'(best);
        res.cell_value = CELL_W'((64'(best) << 16) / n);
        return res;
    endfunction

    function automatic int idle_len(inout int calm);
        int r;
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3)
        begin
            calm = $urandom_range(20, 60);
            return 0;
        end
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 70);
    endfunction

    function automatic logic [FIELD_W-1:0] pick_coord();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return '0;
        if (r < 16)
            return '1;
        if (r < 40)
            return FIELD_W'($urandom_range(500, 507));
        return FIELD_W'($urandom_range(0, 1023));
    endfunction

    function automatic void add_load(input int slot, input logic [FIELD_W-1:0] x,
                                     input logic [FIELD_W-1:0] y);
        nfp_in_t item;
        item.mode = MODE_LOAD;
        item.point_slot = SLOT_W'(slot);
        item.coord_x = x;
        item.coord_y = y;
        feed_items.push_back(item);
        slot_loaded[slot] = 1'b1;
        items_queued++;
    endfunction

    function automatic void add_query(input logic [FIELD_W-1:0] x, input logic [FIELD_W-1:0] y);
        nfp_in_t item;
        item.mode = MODE_QUERY;
        item.point_slot = SLOT_W'($urandom_range(0, TABLE_DEPTH - 1));
        item.coord_x = x;
        item.coord_y = y;
        feed_items.push_back(item);
        items_queued++;
    endfunction

    task automatic wait_drained();
        while (feed_items.size() != 0 || in_valid || nearest_cells.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_point_count(input logic [CNT_CFG_W-1:0] value);
        wait_drained();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= POINT_COUNT_ADDR;
        pwdata  <= APB_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        point_count_cfg = value;
        gen_count = active_points(value);
    endtask

    task automatic random_phase(input logic [CNT_CFG_W-1:0] count_value, input int n_items);
        int                 r, a, b, d;
        logic [FIELD_W-1:0] x, y;
        write_point_count(count_value);
        for (int i = 0; i < gen_count; i++)
            if (!slot_loaded[i])
                add_load(i, pick_coord(), pick_coord());
        for (int k = 0; k < n_items; k++)
        begin
            r = $urandom_range(0, 99);
            if (r < 30)
            begin
                a = (r < 24) ? $urandom_range(0, gen_count - 1) : $urandom_range(0, TABLE_DEPTH - 1);
                add_load(a, pick_coord(), pick_coord());
            end
            else if (r < 42 && gen_count > 1)
            begin
                // two points mirrored around the pixel, equal distance
                a = $urandom_range(0, gen_count - 1);
                b = $urandom_range(0, gen_count - 1);
                d = $urandom_range(0, 15);
                x = FIELD_W'($urandom_range(16, 1007));
                y = pick_coord();
                add_load(a, FIELD_W'(x - d), y);
                add_load(b, FIELD_W'(x + d), y);
                add_query(x, y);
            end
            else
                add_query(pick_coord(), pick_coord());
        end
    endtask

    // input driver, point table tracking and expected results per query
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                if (in_data.mode == MODE_LOAD)
                begin
                    point_x[in_data.point_slot] = in_data.coord_x;
                    point_y[in_data.point_slot] = in_data.coord_y;
                end
                else
                    nearest_cells.push_back(nearest_cell(in_data.coord_x, in_data.coord_y));
            end
            if (!in_valid || in_ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (feed_items.size() != 0)
                begin
                    in_data  <= feed_items.pop_front();
                    in_valid <= 1'b1;
                    send_gap = idle_len(send_calm);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // output ready, with one long hold while items are still queued
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (!long_hold_done && out_valid && feed_items.size() > 8)
            begin
                long_hold_done = 1'b1;
                hold_left = LONG_HOLD;
                out_ready <= 1'b0;
            end
            else if (recv_stall > 0)
            begin
                recv_stall--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                if (out_valid && out_ready)
                    recv_stall = idle_len(recv_calm);
            end
        end
    end

    // result check
    always @(posedge clk)
    begin
        nfp_out_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (nearest_cells.size() == 0)
            begin
                result_errors++;
                if (result_errors <= 10)
                    $display("unexpected transfer: index %0d cell %0d",
                             out_data.nearest_index, out_data.cell_value);
            end
            else
            begin
                want = nearest_cells.pop_front();
                if (out_data.nearest_index !== want.nearest_index ||
                    out_data.cell_value !== want.cell_value)
                begin
                    result_errors++;
                    if (result_errors <= 10)
                        $display("mismatch: expected index %0d cell %0d, got index %0d cell %0d",
                                 want.nearest_index, want.cell_value,
                                 out_data.nearest_index, out_data.cell_value);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) ||
                (psel && penable && pwrite && pready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        logic [FIELD_W-1:0] hi;
        hi = '1;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // count of one after reset
        add_load(0, 0, 0);
        add_query(0, 0);
        add_query(hi, hi);
        add_query(0, hi);
        add_load(255, hi, 0);
        // zero count acts as one
        write_point_count(0);
        add_query(512, 512);
        // ties resolve to the lowest index
        write_point_count(3);
        add_load(1, hi, hi);
        add_load(2, 0, 0);
        add_query(0, 0);
        add_query(hi, hi);
        add_load(1, 0, 0);
        add_query(5, 5);
        add_load(0, hi, 0);
        add_query(0, 0);

        random_phase(2, 30);
        random_phase(256, 40);
        random_phase(511, 40);
        random_phase(255, 20);
        random_phase(1, 20);
        while (items_queued < TARGET_ITEMS)
            random_phase(CNT_CFG_W'($urandom_range(0, 48)), $urandom_range(20, 50));

        wait_drained();
        repeat (30) @(posedge clk);
        if (result_errors == 0 && nearest_cells.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
